@@ hw/rtl/apt_pkg.sv @@
// Shared types, constants, microcode table and helpers for the adaptive pulse threshold block.
package apt_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W   = 10;
	localparam int Q_W        = 26;
	localparam int FRAC_W     = 16;
	localparam int THR_W      = 10;
	localparam int TIME_W     = 32;
	localparam int RATE_W     = 8;
	localparam int ALPHA_W    = 16;
	localparam int K_W        = 12;
	localparam int RR_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W     = 4;
	localparam int MUL_A_W    = ALPHA_W + 1;
	localparam int MUL_B_W    = Q_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int SUM_W      = Q_W + 2;
	localparam int ACC_W      = 39;
	localparam int V_W        = ACC_W - 24;

	localparam logic [Q_W-1:0]   Q16_MAX     = Q_W'(1023 << FRAC_W);
	localparam logic [THR_W-1:0] THR_RESET   = THR_W'(550);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_GAIN  = 3'd0,
		CFG_DEV_GAIN   = 3'd1,
		CFG_K_SIGMA    = 3'd2,
		CFG_THR_MIN    = 3'd3,
		CFG_THR_MAX    = 3'd4,
		CFG_MIN_RR     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] base_gain;
		logic [ALPHA_W-1:0] dev_gain;
		logic [K_W-1:0]     k_sigma;
		logic [THR_W-1:0]   thr_min;
		logic [THR_W-1:0]   thr_max;
		logic [RR_W-1:0]    min_rr;
	} cfg_t;

	// Control word fields
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_BASE,
		MUL_DEV,
		MUL_K
	} mul_op_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_BASE,
		UPD_ERR,
		UPD_DEV,
		UPD_THR,
		UPD_SEED,
		UPD_FIN
	} upd_op_t;

	typedef enum logic [1:0] {
		JMP_DISPATCH,
		JMP_NEXT,
		JMP_FIN,
		JMP_DONE
	} jmp_t;

	typedef struct packed {
		mul_op_t mul;
		upd_op_t upd;
		jmp_t    jmp;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic seeded;
		logic out_block;
	} status_t;

	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_SEED = 4'd8;
	localparam logic [STEP_W-1:0] STEP_FIN  = 4'd9;

	// Microcode ROM: one control word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{mul: MUL_NONE, upd: UPD_NONE, jmp: JMP_DISPATCH};
		unique case (step)
			4'd0: w = '{mul: MUL_NONE, upd: UPD_NONE, jmp: JMP_DISPATCH};
			4'd1: w = '{mul: MUL_BASE, upd: UPD_NONE, jmp: JMP_NEXT};
			4'd2: w = '{mul: MUL_NONE, upd: UPD_BASE, jmp: JMP_NEXT};
			4'd3: w = '{mul: MUL_NONE, upd: UPD_ERR,  jmp: JMP_NEXT};
			4'd4: w = '{mul: MUL_DEV,  upd: UPD_NONE, jmp: JMP_NEXT};
			4'd5: w = '{mul: MUL_NONE, upd: UPD_DEV,  jmp: JMP_NEXT};
			4'd6: w = '{mul: MUL_K,    upd: UPD_NONE, jmp: JMP_NEXT};
			4'd7: w = '{mul: MUL_NONE, upd: UPD_THR,  jmp: JMP_FIN};
			4'd8: w = '{mul: MUL_NONE, upd: UPD_SEED, jmp: JMP_FIN};
			4'd9: w = '{mul: MUL_NONE, upd: UPD_FIN,  jmp: JMP_DONE};
			default: w = '{mul: MUL_NONE, upd: UPD_NONE, jmp: JMP_FIN};
		endcase
		return w;
	endfunction

	// Threshold clamp; the lower limit is checked first, so with crossed limits a value below it gives the lower limit
	function automatic logic [THR_W-1:0] clamp_thr(input logic [V_W-1:0] v,
		input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
		logic [THR_W-1:0] r;
		if (v < V_W'(lo)) begin
			r = lo;
		end else if (v > V_W'(hi)) begin
			r = hi;
		end else begin
			r = v[THR_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/apt_cfg.sv @@
// Configuration register file for the adaptive pulse threshold block.
module apt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apt_pkg::CFG_DATA_W-1:0] cfg_data,
	output apt_pkg::cfg_t                  cfg
);
	import apt_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes, one per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_gain  <= ALPHA_W'(655);
			cfg_q.dev_gain   <= ALPHA_W'(3277);
			cfg_q.k_sigma    <= K_W'(256);
			cfg_q.thr_min    <= THR_W'(400);
			cfg_q.thr_max    <= THR_W'(900);
			cfg_q.min_rr     <= RR_W'(250);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BASE_GAIN:  cfg_q.base_gain  <= cfg_data[ALPHA_W-1:0];
				CFG_DEV_GAIN:   cfg_q.dev_gain   <= cfg_data[ALPHA_W-1:0];
				CFG_K_SIGMA:    cfg_q.k_sigma    <= cfg_data[K_W-1:0];
				CFG_THR_MIN:    cfg_q.thr_min    <= cfg_data[THR_W-1:0];
				CFG_THR_MAX:    cfg_q.thr_max    <= cfg_data[THR_W-1:0];
				CFG_MIN_RR:     cfg_q.min_rr     <= cfg_data[RR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/apt_seq.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
module apt_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             new_sample,
	input  apt_pkg::status_t status,
	output logic             in_ready,
	output apt_pkg::ctrl_t   ctrl
);
	import apt_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	assign ctrl     = ucode(step_q);
	assign in_ready = (ctrl.jmp == JMP_DISPATCH);

	// Next step
	always_comb begin
		step_d = step_q;
		unique case (ctrl.jmp)
			JMP_DISPATCH: begin
				priority if (!in_valid) step_d = step_q;
				else if (!new_sample)   step_d = STEP_FIN;
				else if (!status.seeded) step_d = STEP_SEED;
				else                    step_d = step_q + STEP_W'(1);
			end
			JMP_NEXT: step_d = step_q + STEP_W'(1);
			JMP_FIN:  step_d = STEP_FIN;
			JMP_DONE: step_d = status.out_block ? step_q : STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

`ifndef SYNTH
	// No item accepted means the sequencer stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_IDLE && !in_valid) |=> (step_q == STEP_IDLE))
		else $error("sequencer left idle without a transaction");
	// A finished item holds the final step while the output is blocked
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_FIN && status.out_block) |=> (step_q == STEP_FIN))
		else $error("final step left while output blocked");
`endif

endmodule

@@ hw/rtl/apt_dp.sv @@
// Datapath: shared multiplier, averages, threshold, beat gate and output register.
module apt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  apt_pkg::ctrl_t               ctrl,
	input  apt_pkg::cfg_t                cfg,
	input  logic                         in_accept,
	input  logic [apt_pkg::SAMPLE_W-1:0] sample,
	input  logic                         beat_start,
	input  logic [apt_pkg::RATE_W-1:0]   beat_rate_in,
	input  logic [apt_pkg::TIME_W-1:0]   now_ms,
	input  logic                         out_ready,
	output apt_pkg::status_t             status,
	output logic                         out_valid,
	output logic [apt_pkg::THR_W-1:0]    threshold,
	output logic                         beat_valid,
	output logic [apt_pkg::RATE_W-1:0]   beat_rate_out,
	output logic [apt_pkg::TIME_W-1:0]   beat_time_ms
);
	import apt_pkg::*;

	// Latched transaction
	logic [SAMPLE_W-1:0] sample_q;
	logic                beat_q;
	logic [RATE_W-1:0]   rate_q;
	logic [TIME_W-1:0]   now_q;

	// Filter state
	logic                seeded_q;
	logic [Q_W-1:0]      baseline_q;
	logic [Q_W-1:0]      dev_q;
	logic [Q_W-1:0]      err_q;
	logic [THR_W-1:0]    thr_q;
	logic [TIME_W-1:0]   last_beat_q;
	logic signed [PROD_W-1:0] prod_q;

	// Output register
	logic                out_valid_q;
	logic [THR_W-1:0]    out_thr_q;
	logic                out_beat_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic [TIME_W-1:0]   out_time_q;

	logic [Q_W-1:0]             s_full;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic [Q_W-1:0]             avg_sel;
	logic signed [SUM_W-1:0]    ema_sum;
	logic [Q_W-1:0]             ema_new;
	logic [Q_W-1:0]             err_new;
	logic [ACC_W-1:0]           acc;
	logic [TIME_W-1:0]          elapsed;
	logic                       beat_ok;
	logic                       out_block;
	logic                       fin_go;

	assign s_full = {sample_q, FRAC_W'(0)};

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul)
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MUL_BASE: begin
				mul_a = $signed({1'b0, cfg.base_gain});
				mul_b = $signed({1'b0, s_full}) - $signed({1'b0, baseline_q});
			end
			MUL_DEV: begin
				mul_a = $signed({1'b0, cfg.dev_gain});
				mul_b = $signed({1'b0, err_q}) - $signed({1'b0, dev_q});
			end
			MUL_K: begin
				mul_a = $signed(MUL_A_W'(cfg.k_sigma));
				mul_b = $signed({1'b0, dev_q});
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Average update: avg + floor(prod / 2^16), held to the Q10.16 range
	assign avg_sel = (ctrl.upd == UPD_DEV) ? dev_q : baseline_q;
	assign ema_sum = $signed({2'b00, avg_sel}) + $signed(prod_q[PROD_W-1:FRAC_W]);

	always_comb begin
		if (ema_sum[SUM_W-1]) begin
			ema_new = '0;
		end else if (ema_sum[SUM_W-2:0] > {1'b0, Q16_MAX}) begin
			ema_new = Q16_MAX;
		end else begin
			ema_new = ema_sum[Q_W-1:0];
		end
	end

	// Absolute error against the updated baseline
	assign err_new = (s_full >= baseline_q) ? (s_full - baseline_q) : (baseline_q - s_full);

	// Threshold accumulator: baseline * 2^8 + k * deviation
	assign acc = ACC_W'({baseline_q, 8'b0}) + prod_q[ACC_W-1:0];

	// Refractory gate; a stored time of zero means no beat yet
	assign elapsed = now_q - last_beat_q;
	assign beat_ok = beat_q && !((last_beat_q != '0) && (elapsed < TIME_W'(cfg.min_rr)));

	assign out_block = out_valid_q && !out_ready;
	assign fin_go    = (ctrl.upd == UPD_FIN) && !out_block;

	assign status = '{seeded: seeded_q, out_block: out_block};

	// Transaction fields
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= sample;
			beat_q   <= beat_start;
			rate_q   <= beat_rate_in;
			now_q    <= now_ms;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		if (ctrl.mul != MUL_NONE) begin
			prod_q <= prod;
		end
	end

	// Scratch error register
	always_ff @(posedge clk) begin
		if (ctrl.upd == UPD_ERR) begin
			err_q <= err_new;
		end
	end

	// Filter state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q    <= 1'b0;
			baseline_q  <= '0;
			dev_q       <= '0;
			thr_q       <= THR_RESET;
			last_beat_q <= '0;
		end else begin
			unique case (ctrl.upd)
				UPD_BASE: baseline_q <= ema_new;
				UPD_DEV:  dev_q      <= ema_new;
				UPD_THR:  thr_q      <= clamp_thr(acc[ACC_W-1:ACC_W-V_W],
					cfg.thr_min, cfg.thr_max);
				UPD_SEED: begin
					seeded_q   <= 1'b1;
					baseline_q <= s_full;
					dev_q      <= '0;
					thr_q      <= clamp_thr(V_W'(sample_q), cfg.thr_min, cfg.thr_max);
				end
				UPD_FIN: begin
					if (fin_go && beat_ok) begin
						last_beat_q <= now_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_thr_q  <= thr_q;
			out_beat_q <= beat_ok;
			out_rate_q <= beat_ok ? rate_q : '0;
			out_time_q <= beat_ok ? now_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign threshold     = out_thr_q;
	assign beat_valid    = out_beat_q;
	assign beat_rate_out = out_rate_q;
	assign beat_time_ms  = out_time_q;

`ifndef SYNTH
	// Averages stay in the Q10.16 sample range
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		baseline_q <= Q16_MAX)
		else $error("baseline out of range");
	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		dev_q <= Q16_MAX)
		else $error("deviation out of range");
	// Seeding happens only through the seed step
	a_seed_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!seeded_q && ctrl.upd != UPD_SEED) |=> !seeded_q)
		else $error("seeded set outside seed step");
`endif

endmodule

@@ hw/rtl/adaptive_pulse_threshold_core.sv @@
// Top level of the adaptive pulse threshold block.
//
// Usage: one input transaction per sensor tick on in_valid/in_ready, one result
// transaction per input on out_valid/out_ready, registers on cfg_valid/cfg_ready
// (cfg_ready is always high; write only while the block is idle).
// A fresh sample (new_sample = 1) updates the baseline and deviation averages
// and the clamped threshold; the beat gate applies the refractory interval.
// Each item runs a short microprogram over one shared 17x27 multiplier:
//   stale sample        : final step only
//   first fresh sample  : seed step, then final step
//   later fresh samples : three multiplies, each followed by its update, then final step
// The next item is accepted the cycle after the result is registered, so the
// block takes no new sample before it is through with the last one.
// Results sit in an output register; while the receiver stalls, one more item
// may be accepted and run up to its final step, where it holds, and no further
// input is taken until that register can be loaded.
// Reset clears the configuration to defaults, unseeds the filter, sets the
// threshold to 550 and forgets the last beat time.
module adaptive_pulse_threshold_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           new_sample,
	input  logic [apt_pkg::SAMPLE_W-1:0]   sample,
	input  logic                           beat_start,
	input  logic [apt_pkg::RATE_W-1:0]     beat_rate_in,
	input  logic [apt_pkg::TIME_W-1:0]     now_ms,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [apt_pkg::THR_W-1:0]      threshold,
	output logic                           beat_valid,
	output logic [apt_pkg::RATE_W-1:0]     beat_rate_out,
	output logic [apt_pkg::TIME_W-1:0]     beat_time_ms
);
	import apt_pkg::*;

	cfg_t    cfg;
	ctrl_t   ctrl;
	status_t status;
	logic    in_accept;

	assign in_accept = in_valid && in_ready;

	apt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apt_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.new_sample (new_sample),
		.status     (status),
		.in_ready   (in_ready),
		.ctrl       (ctrl)
	);

	apt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cfg           (cfg),
		.in_accept     (in_accept),
		.sample        (sample),
		.beat_start    (beat_start),
		.beat_rate_in  (beat_rate_in),
		.now_ms        (now_ms),
		.out_ready     (out_ready),
		.status        (status),
		.out_valid     (out_valid),
		.threshold     (threshold),
		.beat_valid    (beat_valid),
		.beat_rate_out (beat_rate_out),
		.beat_time_ms  (beat_time_ms)
	);

`ifndef SYNTH
	// Only one item in flight: no acceptance while a result is being produced
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !in_ready)
		else $error("input accepted while an item is in flight");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the adaptive pulse threshold core.
`timescale 1ns / 100ps

module tb;
	import apt_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 12;

	// One input transaction
	typedef struct packed {
		logic                fresh;
		logic [SAMPLE_W-1:0] smp;
		logic                beat;
		logic [RATE_W-1:0]   bpm;
		logic [TIME_W-1:0]   stamp;
	} tick_t;

	// One result transaction
	typedef struct packed {
		logic [THR_W-1:0]  thr;
		logic              beat_ok;
		logic [RATE_W-1:0] bpm;
		logic [TIME_W-1:0] stamp;
	} detection_t;

	// Directed table row: either a register write or an input item
	typedef struct {
		bit                    is_write;
		cfg_idx_t              sel;
		logic [CFG_DATA_W-1:0] wdata;
		tick_t                 tk;
		bit                    typed;
		detection_t            want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  new_sample;
	logic [SAMPLE_W-1:0]   sample;
	logic                  beat_start;
	logic [RATE_W-1:0]     beat_rate_in;
	logic [TIME_W-1:0]     now_ms;
	logic                  out_valid;
	logic                  out_ready;
	logic [THR_W-1:0]      threshold;
	logic                  beat_valid;
	logic [RATE_W-1:0]     beat_rate_out;
	logic [TIME_W-1:0]     beat_time_ms;

	// Predictor state and register shadow
	cfg_t                  regs;
	logic                  flt_seeded;
	logic [Q_W-1:0]        flt_base;
	logic [Q_W-1:0]        flt_dev;
	logic [THR_W-1:0]      flt_thr;
	logic [TIME_W-1:0]     beat_last;

	detection_t            detections_due[$];
	int                    mismatches;
	int                    items_taken;
	int                    cycles;
	logic [TIME_W-1:0]     clock_ms;
	int                    wave_pos;

	// Receiver stall pattern state
	logic                  rx_hold;
	int                    rx_mode;
	int                    rx_left;
	int                    rx_per;
	int                    rx_cnt;

	adaptive_pulse_threshold_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.new_sample   (new_sample),
		.sample       (sample),
		.beat_start   (beat_start),
		.beat_rate_in (beat_rate_in),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.threshold    (threshold),
		.beat_valid   (beat_valid),
		.beat_rate_out(beat_rate_out),
		.beat_time_ms (beat_time_ms)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Clamp to the configured limits; the lower limit is checked first
	function automatic logic [THR_W-1:0] limit_thr(input longint v);
		if (v < longint'(regs.thr_min)) begin
			return regs.thr_min;
		end else if (v > longint'(regs.thr_max)) begin
			return regs.thr_max;
		end
		return v[THR_W-1:0];
	endfunction

	// Exponential average step in Q10.16, floor of the scaled correction
	function automatic logic [Q_W-1:0] ema(input logic [Q_W-1:0] avg,
		input logic [Q_W-1:0] tgt, input logic [ALPHA_W-1:0] a);
		longint diff;
		longint nxt;
		diff = longint'(tgt) - longint'(avg);
		nxt  = longint'(avg) + ((longint'(a) * diff) >>> FRAC_W);
		if (nxt < 0) begin
			nxt = 0;
		end
		if (nxt > longint'(Q16_MAX)) begin
			nxt = longint'(Q16_MAX);
		end
		return nxt[Q_W-1:0];
	endfunction

	// Threshold tracking and refractory beat gate for one accepted item
	function automatic detection_t detect_step(input tick_t tk);
		detection_t        r;
		logic [Q_W-1:0]    tgt;
		logic [Q_W-1:0]    err;
		logic [TIME_W-1:0] elapsed;
		longint            acc;
		r   = '0;
		tgt = {tk.smp, {FRAC_W{1'b0}}};
		if (tk.fresh) begin
			if (!flt_seeded) begin
				flt_base   = tgt;
				flt_dev    = '0;
				flt_thr    = limit_thr(longint'(tk.smp));
				flt_seeded = 1'b1;
			end else begin
				flt_base = ema(flt_base, tgt, regs.base_gain);
				err      = (tgt >= flt_base) ? tgt - flt_base : flt_base - tgt;
				flt_dev  = ema(flt_dev, err, regs.dev_gain);
				acc      = (longint'(flt_base) << 8) + longint'(regs.k_sigma) * longint'(flt_dev);
				flt_thr  = limit_thr(acc >>> 24);
			end
		end
		elapsed = tk.stamp - beat_last;
		if (tk.beat && !(beat_last != '0 && elapsed < TIME_W'(regs.min_rr))) begin
			beat_last = tk.stamp;
			r.beat_ok = 1'b1;
			r.bpm     = tk.bpm;
			r.stamp   = tk.stamp;
		end
		r.thr = flt_thr;
		return r;
	endfunction

	function automatic void apply_reg(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] v);
		case (sel)
			CFG_BASE_GAIN:  regs.base_gain  = v[ALPHA_W-1:0];
			CFG_DEV_GAIN:   regs.dev_gain   = v[ALPHA_W-1:0];
			CFG_K_SIGMA:    regs.k_sigma    = v[K_W-1:0];
			CFG_THR_MIN:    regs.thr_min    = v[THR_W-1:0];
			CFG_THR_MAX:    regs.thr_max    = v[THR_W-1:0];
			CFG_MIN_RR:     regs.min_rr     = v[RR_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic tick_t mk_tick(input int f, input int s, input int b,
		input int bpm, input logic [TIME_W-1:0] t);
		tick_t tk;
		tk.fresh = 1'(f);
		tk.smp   = SAMPLE_W'(s);
		tk.beat  = 1'(b);
		tk.bpm   = RATE_W'(bpm);
		tk.stamp = t;
		return tk;
	endfunction

	function automatic detection_t mk_det(input int thr, input int ok, input int bpm,
		input logic [TIME_W-1:0] t);
		detection_t d;
		d.thr     = THR_W'(thr);
		d.beat_ok = 1'(ok);
		d.bpm     = RATE_W'(bpm);
		d.stamp   = t;
		return d;
	endfunction

	function automatic dir_row_t item_row(input tick_t tk, input int typed, input detection_t want);
		dir_row_t row;
		row.is_write = 1'b0;
		row.sel      = CFG_BASE_GAIN;
		row.wdata    = '0;
		row.tk       = tk;
		row.typed    = 1'(typed);
		row.want     = want;
		return row;
	endfunction

	function automatic dir_row_t write_row(input cfg_idx_t sel, input int v);
		dir_row_t row;
		row.is_write = 1'b1;
		row.sel      = sel;
		row.wdata    = CFG_DATA_W'(v);
		row.tk       = '0;
		row.typed    = 1'b0;
		row.want     = '0;
		return row;
	endfunction

	function automatic cfg_t rand_regs();
		cfg_t c;
		c.base_gain  = ALPHA_W'($urandom_range(0, 65535));
		c.dev_gain   = ALPHA_W'($urandom_range(0, 65535));
		c.k_sigma    = K_W'($urandom_range(0, 4095));
		c.thr_min    = THR_W'($urandom_range(0, 1023));
		c.thr_max    = THR_W'($urandom_range(0, 1023));
		c.min_rr     = RR_W'($urandom_range(0, 2000));
		return c;
	endfunction

	// Random item: pulse-like waveform mixed with uniform and extreme samples,
	// time mostly advancing around the refractory interval with rare jumps
	function automatic tick_t draw_tick();
		tick_t tk;
		int    r;
		int    lvl;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			lvl = $urandom_range(0, 1) ? 1023 : 0;
		end else if (r < 5) begin
			lvl = $urandom_range(0, 1023);
		end else begin
			wave_pos++;
			lvl = ((wave_pos % 40) < 6 ? 780 : 470) + $urandom_range(0, 60) - 30;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			clock_ms = $urandom();
		end else if (r < 3) begin
			clock_ms = '0;
		end else if (r < 4) begin
			clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 600));
		end else begin
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 2 * int'(regs.min_rr) + 20));
		end
		tk.fresh = ($urandom_range(0, 3) != 0);
		tk.smp   = SAMPLE_W'(lvl);
		tk.beat  = ($urandom_range(0, 9) < 3);
		tk.bpm   = RATE_W'($urandom_range(0, 255));
		tk.stamp = clock_ms;
		return tk;
	endfunction

	// Present one input transaction and queue its expected result
	task automatic offer(input tick_t tk, input bit typed, input detection_t want);
		detection_t got;
		new_sample   <= tk.fresh;
		sample       <= tk.smp;
		beat_start   <= tk.beat;
		beat_rate_in <= tk.bpm;
		now_ms       <= tk.stamp;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = detect_step(tk);
		detections_due.push_back(typed ? want : got);
		items_taken++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		while (detections_due.size() != 0) @(posedge clk);
	endtask

	// Register write; cfg_valid stays high for back-to-back writes
	task automatic write_reg(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(sel, v);
	endtask

	task automatic load_regs(input cfg_t c);
		write_reg(CFG_BASE_GAIN,  CFG_DATA_W'(c.base_gain));
		write_reg(CFG_DEV_GAIN,   CFG_DATA_W'(c.dev_gain));
		write_reg(CFG_K_SIGMA,    CFG_DATA_W'(c.k_sigma));
		write_reg(CFG_THR_MIN,    CFG_DATA_W'(c.thr_min));
		write_reg(CFG_THR_MAX,    CFG_DATA_W'(c.thr_max));
		write_reg(CFG_MIN_RR,     CFG_DATA_W'(c.min_rr));
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (seen !== want) begin
			mismatches++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, seen);
		end
	endfunction

	// Result monitor
	always @(posedge clk) begin : mon
		detection_t due;
		if (arst_n && out_valid && out_ready) begin
			if (detections_due.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: expected none actual thr %0d beat %0b",
					$time, threshold, beat_valid);
			end else begin
				due = detections_due.pop_front();
				check_field("threshold", 32'(due.thr), 32'(threshold));
				check_field("beat_valid", 32'(due.beat_ok), 32'(beat_valid));
				check_field("beat_rate_out", 32'(due.bpm), 32'(beat_rate_out));
				check_field("beat_time_ms", due.stamp, beat_time_ms);
			end
		end
	end

	// Receiver: stall mode is redrawn at random whenever its random run length is used up
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_per  = $urandom_range(2, 8);
			rx_left = $urandom_range(16, 200);
			rx_cnt  = 0;
		end
		rx_left--;
		rx_cnt++;
		case (rx_mode)
			0:       out_ready <= !rx_hold;
			1:       out_ready <= !rx_hold && $urandom_range(0, 1);
			2:       out_ready <= !rx_hold && (rx_cnt % rx_per == 0);
			default: out_ready <= !rx_hold && ($urandom_range(0, 7) != 0);
		endcase
	end

	// Long receiver hold-offs while the sender keeps offering
	initial begin
		rx_hold <= 1'b0;
		while (items_taken < 400) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
		while (items_taken < 1200) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : main
		dir_row_t rows[$];
		cfg_t     plan[6];
		bit       writing;
		int       left;
		int       burst;

		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		new_sample   <= 1'b0;
		sample       <= '0;
		beat_start   <= 1'b0;
		beat_rate_in <= '0;
		now_ms       <= '0;
		items_taken  = 0;
		clock_ms     = '0;
		wave_pos     = 0;
		regs         = '{base_gain: 16'd655, dev_gain: 16'd3277, k_sigma: 12'd256,
			thr_min: 10'd400, thr_max: 10'd900, min_rr: 16'd250};
		flt_seeded   = 1'b0;
		flt_base     = '0;
		flt_dev      = '0;
		flt_thr      = THR_W'(550);
		beat_last    = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, starting from reset defaults
		// stale sample right after reset shows the default threshold
		rows.push_back(item_row(mk_tick(0, 1023, 0, 0, 0), 1, mk_det(550, 0, 0, 0)));
		// beat at time zero is taken and leaves no beat on record
		rows.push_back(item_row(mk_tick(0, 0, 1, 255, 0), 1, mk_det(550, 1, 255, 0)));
		rows.push_back(item_row(mk_tick(0, 0, 1, 7, 5), 1, mk_det(550, 1, 7, 5)));
		// inside the refractory interval
		rows.push_back(item_row(mk_tick(0, 0, 1, 9, 100), 1, mk_det(550, 0, 0, 0)));
		// exactly at the interval
		rows.push_back(item_row(mk_tick(0, 0, 1, 8, 255), 1, mk_det(550, 1, 8, 255)));
		rows.push_back(item_row(mk_tick(0, 0, 1, 128, 32'hFFFF_FFF0), 1,
			mk_det(550, 1, 128, 32'hFFFF_FFF0)));
		// elapsed time across the wrap: too soon, then just enough
		rows.push_back(item_row(mk_tick(0, 0, 1, 1, 5), 1, mk_det(550, 0, 0, 0)));
		rows.push_back(item_row(mk_tick(0, 0, 1, 2, 32'hF0), 1, mk_det(550, 1, 2, 32'hF0)));
		// first fresh sample seeds, clamped up to thr_min
		rows.push_back(item_row(mk_tick(1, 0, 0, 0, 32'h100), 1, mk_det(400, 0, 0, 0)));
		rows.push_back(item_row(mk_tick(1, 1023, 1, 170, 32'h1F0), 0, '0));
		rows.push_back(item_row(mk_tick(1, 0, 0, 85, 32'h200), 0, '0));
		rows.push_back(item_row(mk_tick(0, 682, 0, 0, 32'h210), 0, '0));
		rows.push_back(item_row(mk_tick(0, 341, 1, 0, 32'h220), 0, '0));
		// crossed limits: below thr_min gives thr_min, anything else thr_max
		rows.push_back(write_row(CFG_THR_MIN, 1000));
		rows.push_back(write_row(CFG_THR_MAX, 100));
		rows.push_back(item_row(mk_tick(1, 512, 0, 0, 32'h230), 1, mk_det(1000, 0, 0, 0)));
		rows.push_back(write_row(CFG_K_SIGMA, 4095));
		rows.push_back(write_row(CFG_BASE_GAIN, 65535));
		rows.push_back(write_row(CFG_DEV_GAIN, 65535));
		rows.push_back(item_row(mk_tick(1, 1023, 0, 0, 32'h240), 1, mk_det(100, 0, 0, 0)));
		// longest refractory interval, then none at all
		rows.push_back(write_row(CFG_MIN_RR, 65535));
		rows.push_back(write_row(CFG_THR_MIN, 0));
		rows.push_back(write_row(CFG_THR_MAX, 1023));
		rows.push_back(item_row(mk_tick(1, 0, 1, 33, 32'h5D8), 0, '0));
		rows.push_back(write_row(CFG_MIN_RR, 0));
		rows.push_back(item_row(mk_tick(0, 0, 1, 85, 32'h1F0), 0, '0));
		rows.push_back(item_row(mk_tick(1, 700, 1, 86, 32'h1F0), 0, '0));

		writing = 1'b0;
		foreach (rows[i]) begin
			if (rows[i].is_write) begin
				if (!writing) begin
					settle();
					writing = 1'b1;
				end
				write_reg(rows[i].sel, rows[i].wdata);
			end else begin
				if (writing) begin
					cfg_valid <= 1'b0;
					writing = 1'b0;
				end
				offer(rows[i].tk, rows[i].typed, rows[i].want);
			end
		end

		// Random phases, each under its own register setting
		plan[0] = '{base_gain: 16'd655, dev_gain: 16'd3277, k_sigma: 12'd256,
			thr_min: 10'd400, thr_max: 10'd900, min_rr: 16'd250};
		plan[1] = rand_regs();
		plan[2] = '{base_gain: 16'hFFFF, dev_gain: 16'hFFFF, k_sigma: 12'hFFF,
			thr_min: 10'd0, thr_max: 10'd1023, min_rr: 16'hFFFF};
		plan[3] = rand_regs();
		plan[4] = '{base_gain: 16'd0, dev_gain: 16'd0, k_sigma: 12'd0,
			thr_min: 10'd1023, thr_max: 10'd0, min_rr: 16'd0};
		plan[5] = '{base_gain: 16'd32768, dev_gain: 16'd16384, k_sigma: 12'd512,
			thr_min: 10'd100, thr_max: 10'd800, min_rr: 16'd20};

		foreach (plan[p]) begin
			settle();
			load_regs(plan[p]);
			left = PHASE_ITEMS;
			while (left > 0) begin
				burst = $urandom_range(1, 40);
				while (burst > 0 && left > 0) begin
					offer(draw_tick(), 1'b0, '0);
					burst--;
					left--;
				end
				if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && detections_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
